// ----- design/meb_pkg.sv -----
// meb_pkg: types, codes and byte constants shared by the midi event encoder
// no dependencies; meb_front, meb_queue, meb_back and the top refer to it by scoped names
`default_nettype none

package meb_pkg;

  // event kinds carried in the mode field
  typedef enum logic [3:0] {
    MODE_PROGRAM = 4'd0,
    MODE_NOTE_ON = 4'd1,
    MODE_NOTE_OFF = 4'd2,
    MODE_BEND = 4'd3,
    MODE_CONTROL = 4'd4,
    MODE_TEMPO = 4'd5,
    MODE_BEGIN = 4'd6,
    MODE_END = 4'd7,
    MODE_HEADER = 4'd8
  } meb_mode_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_NO_TRACK = 2'd1,
    STATUS_BAD_PARAM = 2'd2
  } meb_status_t;

  // sizes
  localparam int unsigned MAX_BYTES = 14;
  localparam int unsigned VLQ_BYTES = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [14:0] TPQ_RESET = 15'd480;

  // status and meta bytes
  localparam logic [7:0] ST_NOTE_ON = 8'h90;
  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_PROGRAM = 8'hC0;
  localparam logic [7:0] ST_CONTROL = 8'hB0;
  localparam logic [7:0] ST_BEND = 8'hE0;
  localparam logic [7:0] META = 8'hFF;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_END = 8'h2F;
  localparam logic [7:0] TEMPO_LEN = 8'h03;
  localparam logic [7:0] DATA_MAX = 8'h7F;
  localparam logic [7:0] CHAN_MAX = 8'h0F;
  localparam logic [17:0] BEND_CENTER = 18'd8192;
  localparam logic [13:0] BEND_MAX = 14'd16383;
  localparam logic [7:0] HDR_LEN = 8'h06;

  // one classified event waiting to be serialized
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;  // element 0 goes out first
    logic [3:0] count;                 // results for this event, 1..14
    logic has_data;                    // 0 for a rejected event
    meb_status_t status;
    logic [31:0] tlen;                 // reported on the final result
  } meb_entry_t;

  // queue flags seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } meb_qstat_t;

endpackage

`default_nettype wire

// ----- design/meb_if.sv -----
// meb_in_if / meb_out_if: valid-ready channels of the midi event encoder
// no dependencies
`default_nettype none

interface meb_in_if;
  logic valid;
  logic ready;
  logic [3:0] mode;
  logic [27:0] delta_ticks;
  logic [7:0] channel;
  logic [7:0] first_data;
  logic [7:0] second_data;
  logic signed [15:0] bend_amount;
  logic [23:0] tempo_us;
  logic [15:0] track_total;

  modport source (
    output valid, mode, delta_ticks, channel, first_data, second_data,
           bend_amount, tempo_us, track_total,
    input ready
  );
  modport sink (
    input valid, mode, delta_ticks, channel, first_data, second_data,
          bend_amount, tempo_us, track_total,
    output ready
  );
endinterface

interface meb_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic byte_valid;
  logic [1:0] status;
  logic last;
  logic [31:0] track_length;

  modport source (
    output valid, out_byte, byte_valid, status, last, track_length,
    input ready
  );
  modport sink (
    input valid, out_byte, byte_valid, status, last, track_length,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/meb_front.sv -----
// meb_front: accepts event words, checks them, builds the byte list and
// keeps track state; depends on meb_pkg and meb_in_if
`default_nettype none

module meb_front (
  input  wire                  clk,
  input  wire                  rst_n,
  meb_in_if.sink               in_if,
  input  wire                  cfg_we,
  input  wire [14:0]           cfg_wdata,
  input  meb_pkg::meb_qstat_t  qstat,
  output logic                 push,
  output meb_pkg::meb_entry_t  entry
);

  logic [14:0] tpq_r, tpq_nxt;
  logic        open_r, open_nxt;
  logic [31:0] tbytes_r, tbytes_nxt;

  logic [meb_pkg::VLQ_BYTES-1:0][7:0] vlq;
  logic [2:0]  vlq_n;
  logic [meb_pkg::MAX_BYTES-1:0][7:0] body;
  logic [3:0]  body_n;
  logic [3:0]  total;
  logic        bad, no_track, counted, ending, opening;
  logic [17:0] bsum;
  logic [13:0] bend;
  logic [32:0] tsum;
  logic [31:0] tsat;
  logic [3:0]  sel;
  logic [3:0]  ch;
  logic        accept;

  assign in_if.ready = !qstat.full;
  assign accept = in_if.valid && in_if.ready;
  assign push = accept;
  assign ch = in_if.channel[3:0];

  // delta time as variable length quantity, high group first
  always_comb begin
    vlq = '0;
    if (in_if.delta_ticks[27:21] != 7'd0) begin
      vlq_n = 3'd4;
      vlq[0] = {1'b1, in_if.delta_ticks[27:21]};
      vlq[1] = {1'b1, in_if.delta_ticks[20:14]};
      vlq[2] = {1'b1, in_if.delta_ticks[13:7]};
      vlq[3] = {1'b0, in_if.delta_ticks[6:0]};
    end else if (in_if.delta_ticks[20:14] != 7'd0) begin
      vlq_n = 3'd3;
      vlq[0] = {1'b1, in_if.delta_ticks[20:14]};
      vlq[1] = {1'b1, in_if.delta_ticks[13:7]};
      vlq[2] = {1'b0, in_if.delta_ticks[6:0]};
    end else if (in_if.delta_ticks[13:7] != 7'd0) begin
      vlq_n = 3'd2;
      vlq[0] = {1'b1, in_if.delta_ticks[13:7]};
      vlq[1] = {1'b0, in_if.delta_ticks[6:0]};
    end else begin
      vlq_n = 3'd1;
      vlq[0] = {1'b0, in_if.delta_ticks[6:0]};
    end
  end

  // pitch bend offset and clamp to 14 bits
  always_comb begin
    bsum = {{2{in_if.bend_amount[15]}}, in_if.bend_amount} + meb_pkg::BEND_CENTER;
    if (bsum[17]) begin
      bend = '0;
    end else if (bsum[16:14] != 3'd0) begin
      bend = meb_pkg::BEND_MAX;
    end else begin
      bend = bsum[13:0];
    end
  end

  // event body and parameter checks
  always_comb begin
    body = '0;
    body_n = 4'd0;
    bad = 1'b0;
    no_track = 1'b0;
    counted = 1'b0;
    ending = 1'b0;
    opening = 1'b0;
    case (meb_pkg::meb_mode_t'(in_if.mode))
      meb_pkg::MODE_PROGRAM: begin
        body[0] = meb_pkg::ST_PROGRAM | {4'd0, ch};
        body[1] = in_if.first_data;
        body_n = 4'd2;
        bad = (in_if.channel > meb_pkg::CHAN_MAX) || (in_if.first_data > meb_pkg::DATA_MAX);
        no_track = !open_r;
        counted = 1'b1;
      end
      meb_pkg::MODE_NOTE_ON, meb_pkg::MODE_CONTROL: begin
        body[0] = ((in_if.mode == meb_pkg::MODE_NOTE_ON) ? meb_pkg::ST_NOTE_ON
                                                         : meb_pkg::ST_CONTROL) | {4'd0, ch};
        body[1] = in_if.first_data;
        body[2] = in_if.second_data;
        body_n = 4'd3;
        bad = (in_if.channel > meb_pkg::CHAN_MAX) || (in_if.first_data > meb_pkg::DATA_MAX)
              || (in_if.second_data > meb_pkg::DATA_MAX);
        no_track = !open_r;
        counted = 1'b1;
      end
      meb_pkg::MODE_NOTE_OFF: begin
        body[0] = meb_pkg::ST_NOTE_OFF | {4'd0, ch};
        body[1] = in_if.first_data;
        body_n = 4'd3;
        bad = (in_if.channel > meb_pkg::CHAN_MAX) || (in_if.first_data > meb_pkg::DATA_MAX);
        no_track = !open_r;
        counted = 1'b1;
      end
      meb_pkg::MODE_BEND: begin
        body[0] = meb_pkg::ST_BEND | {4'd0, ch};
        body[1] = {1'b0, bend[6:0]};
        body[2] = {1'b0, bend[13:7]};
        body_n = 4'd3;
        bad = in_if.channel > meb_pkg::CHAN_MAX;
        no_track = !open_r;
        counted = 1'b1;
      end
      meb_pkg::MODE_TEMPO: begin
        body[0] = meb_pkg::META;
        body[1] = meb_pkg::META_TEMPO;
        body[2] = meb_pkg::TEMPO_LEN;
        body[3] = in_if.tempo_us[23:16];
        body[4] = in_if.tempo_us[15:8];
        body[5] = in_if.tempo_us[7:0];
        body_n = 4'd6;
        no_track = !open_r;
        counted = 1'b1;
      end
      meb_pkg::MODE_BEGIN: begin
        body[0] = 8'h4D;  // M
        body[1] = 8'h54;  // T
        body[2] = 8'h72;  // r
        body[3] = 8'h6B;  // k
        body_n = 4'd8;
        opening = 1'b1;
      end
      meb_pkg::MODE_END: begin
        body[1] = meb_pkg::META;
        body[2] = meb_pkg::META_END;
        body_n = 4'd4;
        no_track = !open_r;
        counted = 1'b1;
        ending = 1'b1;
      end
      meb_pkg::MODE_HEADER: begin
        body[0] = 8'h4D;  // M
        body[1] = 8'h54;  // T
        body[2] = 8'h68;  // h
        body[3] = 8'h64;  // d
        body[7] = meb_pkg::HDR_LEN;
        body[9] = {7'd0, (in_if.track_total > 16'd1)};
        body[10] = in_if.track_total[15:8];
        body[11] = in_if.track_total[7:0];
        body[12] = {1'b0, tpq_r[14:8]};
        body[13] = tpq_r[7:0];
        body_n = 4'd14;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  // saturating track byte count after this event
  always_comb begin
    tsum = {1'b0, tbytes_r} + {29'd0, total};
    tsat = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
  end

  // splice delta bytes and body into one list
  always_comb begin
    total = (counted && !opening && (in_if.mode != meb_pkg::MODE_END))
            ? ({1'b0, vlq_n} + body_n) : body_n;
    entry = '0;
    if (no_track || bad) begin
      entry.count = 4'd1;
      entry.has_data = 1'b0;
      entry.status = no_track ? meb_pkg::STATUS_NO_TRACK : meb_pkg::STATUS_BAD_PARAM;
    end else begin
      entry.count = total;
      entry.has_data = 1'b1;
      entry.status = meb_pkg::STATUS_OK;
      entry.tlen = ending ? tsat : 32'd0;
    end
    for (int i = 0; i < meb_pkg::MAX_BYTES; i++) begin
      sel = 4'(i);
      if (total != body_n) begin
        if (sel < {1'b0, vlq_n}) begin
          entry.bytes[i] = vlq[sel[1:0]];
        end else begin
          entry.bytes[i] = body[sel - {1'b0, vlq_n}];
        end
      end else begin
        entry.bytes[i] = body[i];
      end
    end
  end

  // track state and division register
  always_comb begin
    tpq_nxt = cfg_we ? cfg_wdata : tpq_r;
    open_nxt = open_r;
    tbytes_nxt = tbytes_r;
    if (accept && !no_track && !bad) begin
      if (opening) begin
        open_nxt = 1'b1;
        tbytes_nxt = '0;
      end
      if (counted) begin
        tbytes_nxt = tsat;
      end
      if (ending) begin
        open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpq_r <= meb_pkg::TPQ_RESET;
      open_r <= 1'b0;
      tbytes_r <= '0;
    end else begin
      tpq_r <= tpq_nxt;
      open_r <= open_nxt;
      tbytes_r <= tbytes_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/meb_queue.sv -----
// meb_queue: short fifo of classified events between front and back
// depends on meb_pkg
`default_nettype none

module meb_queue #(
  parameter int unsigned DEPTH = meb_pkg::QUEUE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  meb_pkg::meb_entry_t  wdata,
  input  wire                  pop,
  output meb_pkg::meb_entry_t  rdata,
  output meb_pkg::meb_qstat_t  qstat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  meb_pkg::meb_entry_t slot_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign qstat.full = (cnt_r == CW'(DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign rdata = slot_r[rp_r];

  // pointer and fill updates
  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- design/meb_back.sv -----
// meb_back: walks the queue head one byte per cycle into the output register while
// out_if.ready is high or no word is held; depends on meb_pkg and meb_out_if
`default_nettype none

module meb_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  meb_pkg::meb_entry_t  head,
  input  meb_pkg::meb_qstat_t  qstat,
  output logic                 pop,
  meb_out_if.source            out_if
);

  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        bvalid_r, bvalid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        last_r, last_nxt;
  logic [31:0] tlen_r, tlen_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        load, fin;

  assign load = !valid_r || out_if.ready;
  assign fin = (idx_r == head.count - 4'd1);
  assign pop = load && !qstat.empty && fin;

  assign out_if.valid = valid_r;
  assign out_if.out_byte = byte_r;
  assign out_if.byte_valid = bvalid_r;
  assign out_if.status = status_r;
  assign out_if.last = last_r;
  assign out_if.track_length = tlen_r;

  // next output word and byte index
  always_comb begin
    valid_nxt = valid_r;
    byte_nxt = byte_r;
    bvalid_nxt = bvalid_r;
    status_nxt = status_r;
    last_nxt = last_r;
    tlen_nxt = tlen_r;
    idx_nxt = idx_r;
    if (load) begin
      valid_nxt = !qstat.empty;
      if (!qstat.empty) begin
        byte_nxt = head.has_data ? head.bytes[idx_r] : 8'd0;
        bvalid_nxt = head.has_data;
        status_nxt = head.status;
        last_nxt = fin;
        tlen_nxt = fin ? head.tlen : 32'd0;
        idx_nxt = fin ? 4'd0 : idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    bvalid_r <= bvalid_nxt;
    status_r <= status_nxt;
    last_r <= last_nxt;
    tlen_r <= tlen_nxt;
  end

`ifndef NO_ASSERTIONS
  // a rejected event is always a single final word
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !bvalid_r |-> last_r)
    else $error("rejected word not marked last");

  // byte index never runs past the head event
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    !qstat.empty |-> idx_r < head.count)
    else $error("byte index beyond event length");

  // index returns to zero after an event is popped
  a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> idx_r == 4'd0)
    else $error("byte index not cleared after pop");

  // track length only appears on a final word
  a_tlen_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (tlen_r != 32'd0) |-> last_r)
    else $error("track length on non-final word");
`endif

endmodule

`default_nettype wire

// ----- design/midi_event_byte_encoder_top.sv -----
// midi_event_byte_encoder_top: standard midi file event encoder
// depends on meb_pkg, meb_if, meb_front, meb_queue, meb_back
//
// usage:
//   in_if carries one event request per word (valid/ready); out_if returns
//   the file bytes of that event one word per cycle while out_if.ready is high,
//   the final one flagged by last. a rejected event gives a single word with
//   byte_valid low and a status code. cfg_we/cfg_wdata write the ticks-per-quarter division.
// flow:
//   an accepted event is written into the queue, and from the queue head its
//   first byte is loaded into the output register. an event has 1 to 14
//   result words; this one byte per cycle output register sets the rate
//   while out_if.ready is high, and consecutive events stream with no gap.
//   the queue holds QUEUE_DEPTH classified events, so the next request is
//   taken while earlier bytes still drain.
// reset:
//   synchronous active low; no track open, byte count zero, division 480,
//   queue and output empty. no clearing pass.
// stall:
//   when out_if.ready is low the output word holds; the queue fills and
//   in_if.ready drops once it is full.
`default_nettype none

module midi_event_byte_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = meb_pkg::QUEUE_DEPTH
) (
  input  wire          clk,
  input  wire          rst_n,
  meb_in_if.sink       in_if,
  meb_out_if.source    out_if,
  input  wire          cfg_we,
  input  wire [14:0]   cfg_wdata
);

  meb_pkg::meb_entry_t wentry, hentry;
  meb_pkg::meb_qstat_t qstat;
  logic push, pop;

  // classify and check requests
  meb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .qstat     (qstat),
    .push      (push),
    .entry     (wentry)
  );

  // decoupling queue
  meb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wentry),
    .pop   (pop),
    .rdata (hentry),
    .qstat (qstat)
  );

  // byte serializer
  meb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (hentry),
    .qstat  (qstat),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule

`default_nettype wire
